// ===== design/dntw_pkg.sv =====
package dntw_pkg;

	// limits of the text and wire forms
	localparam int MaxTextChars = 1004;
	localparam int LabelMax     = 63;
	localparam int WireMax      = 255;
	localparam int CountSat     = 2047;

	// characters of interest
	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChDot       = 8'h2E;
	localparam logic [7:0] ChDigit0    = 8'h30;
	localparam logic [7:0] ChDigit9    = 8'h39;
	localparam logic [7:0] ChUpperA    = 8'h41;
	localparam logic [7:0] ChUpperZ    = 8'h5A;
	localparam logic [7:0] LowerOffset = 8'd32;

	// byte that ends a name with no trailing dot
	localparam logic [7:0] OpenEndByte = 8'hFF;

	// status codes
	localparam logic [1:0] StValid   = 2'd0;
	localparam logic [1:0] StPartial = 2'd1;
	localparam logic [1:0] StInvalid = 2'd2;

	// most result items one input item can cause
	localparam int MaxBurst = 4;

	// escape decoder state
	typedef enum logic [3:0] {
		ESC_NONE  = 4'b0001,
		ESC_START = 4'b0010,
		ESC_ONE   = 4'b0100,
		ESC_TWO   = 4'b1000
	} esc_t;

	// one result item
	typedef struct packed {
		logic [7:0] wire_offset;
		logic [7:0] wire_byte;
		logic [1:0] status;
		logic       final_result;
	} res_t;

	function automatic res_t make_res(input logic [7:0] off, input logic [7:0] val,
			input logic [1:0] st, input logic fin);
		res_t r;
		r.wire_offset  = off;
		r.wire_byte    = val;
		r.status       = st;
		r.final_result = fin;
		return r;
	endfunction

endpackage

// ===== design/dns_name_text_to_wire_top.sv =====
// flow: an item is registered at acceptance, then its result items are loaded into the burst
// register once that is free and offered on the output, one per cycle while out_ready is high
// throughput: one item per cycle while out_ready is high and each item causes at most one
// result item; an item causing several result items holds the single result port until all are taken
// reset: arst_n clears the item register, the result burst and all name state at once
module dns_name_text_to_wire_top
	import dntw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       last_char,
	input  logic       empty_name,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] wire_offset,
	output logic [7:0] wire_byte,
	output logic [1:0] status,
	output logic       final_result
);

	// input item register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       empty_s1;

	// name state
	esc_t        esc_q;
	logic [6:0]  esc_val_q;
	logic [5:0]  label_q;
	logic        label_has_q;
	logic [8:0]  total_q;
	logic [10:0] chars_q;
	logic        failed_q;

	// result burst register
	res_t       burst_q [MaxBurst];
	logic [2:0] burst_cnt_q;
	logic [1:0] burst_idx_q;

	logic pop, last_pop, burst_free, advance;

	// burst drain control
	assign out_valid  = (burst_cnt_q != 3'd0);
	assign pop        = out_valid && out_ready;
	assign last_pop   = pop && (({1'b0, burst_idx_q} + 3'd1) == burst_cnt_q);
	assign burst_free = (burst_cnt_q == 3'd0) || last_pop;
	assign advance    = valid_s1 && burst_free;
	assign in_ready   = !valid_s1 || burst_free;

	assign wire_offset  = burst_q[burst_idx_q].wire_offset;
	assign wire_byte    = burst_q[burst_idx_q].wire_byte;
	assign status       = burst_q[burst_idx_q].status;
	assign final_result = burst_q[burst_idx_q].final_result;

	// next-state values of one item
	esc_t        esc_n;
	logic [6:0]  esc_val_n;
	logic [5:0]  label_n;
	logic        label_has_n;
	logic [8:0]  total_n;
	logic [10:0] chars_n;
	logic        failed_n;
	logic        clear_n;
	res_t        res [MaxBurst];
	logic [2:0]  res_cnt;
	logic        load_fin;

	// decode one character and build its result items
	always_comb begin
		logic       rdy;
		logic       dot;
		logic       dig;
		logic       done;
		logic [7:0] b;
		logic [9:0] v;
		logic [6:0] nl;

		esc_n       = esc_q;
		esc_val_n   = esc_val_q;
		label_n     = label_q;
		label_has_n = label_has_q;
		total_n     = total_q;
		chars_n     = chars_q;
		failed_n    = failed_q;
		clear_n     = 1'b0;
		res_cnt     = 3'd0;
		for (int i = 0; i < MaxBurst; i++) begin
			res[i] = '0;
		end
		rdy  = 1'b0;
		dot  = 1'b0;
		done = 1'b0;
		b    = ch_s1;
		nl   = 7'(label_q) + 7'd1;
		dig  = (ch_s1 >= ChDigit0) && (ch_s1 <= ChDigit9);
		v    = 10'(esc_val_q) * 10'd10 + 10'(ch_s1[3:0]);

		if (empty_s1) begin
			// zero-length item ends the name
			clear_n = 1'b1;
			if (!failed_q && chars_q == 11'd0) begin
				res[0]  = make_res(total_q[7:0], OpenEndByte, StValid, 1'b0);
				res[1]  = make_res(8'd0, total_q[7:0], StPartial, 1'b1);
				res_cnt = 3'd2;
			end else begin
				res[0]  = make_res(8'd0, 8'd0, StInvalid, 1'b1);
				res_cnt = 3'd1;
			end
		end else begin
			// character count, saturating
			if (chars_q != 11'(CountSat)) begin
				chars_n = chars_q + 11'd1;
			end
			if (chars_n > 11'(MaxTextChars)) begin
				failed_n = 1'b1;
			end

			// escape decoding
			if (!failed_n) begin
				unique case (esc_q)
					ESC_NONE: begin
						if (ch_s1 == ChBackslash) begin
							esc_n       = ESC_START;
							label_has_n = 1'b1;
						end else if (ch_s1 == ChDot) begin
							dot = 1'b1;
						end else begin
							rdy         = 1'b1;
							label_has_n = 1'b1;
						end
					end
					ESC_START: begin
						if (dig) begin
							esc_val_n = 7'(ch_s1[3:0]);
							esc_n     = ESC_ONE;
						end else begin
							rdy   = 1'b1;
							esc_n = ESC_NONE;
						end
					end
					ESC_ONE: begin
						if (dig) begin
							esc_val_n = v[6:0];
							esc_n     = ESC_TWO;
						end else begin
							failed_n = 1'b1;
						end
					end
					ESC_TWO: begin
						if (dig && v <= 10'(WireMax)) begin
							b         = v[7:0];
							rdy       = 1'b1;
							esc_n     = ESC_NONE;
							esc_val_n = 7'd0;
						end else begin
							failed_n = 1'b1;
						end
					end
					default: failed_n = 1'b1;
				endcase
			end

			// label data byte
			if (!failed_n && rdy) begin
				if (b >= ChUpperA && b <= ChUpperZ) begin
					b = b + LowerOffset;
				end
				if (nl > 7'(LabelMax)
						|| (10'(nl) + 10'd1 + 10'(total_q)) > 10'(WireMax)) begin
					failed_n = 1'b1;
				end else begin
					res[res_cnt[1:0]] = make_res(8'(total_q + 9'(nl)), b, StValid, 1'b0);
					res_cnt           = res_cnt + 3'd1;
					label_n           = nl[5:0];
				end
			end

			// dot closes a label, or is the root name
			if (!failed_n && dot) begin
				if (!label_has_n) begin
					if (last_s1 && chars_n == 11'd1) begin
						res[0]  = make_res(total_n[7:0], 8'd0, StValid, 1'b0);
						res[1]  = make_res(8'd0, total_n[7:0], StValid, 1'b1);
						res_cnt = 3'd2;
						clear_n = 1'b1;
						done    = 1'b1;
					end else begin
						failed_n = 1'b1;
					end
				end else begin
					res[res_cnt[1:0]] = make_res(total_n[7:0], 8'(label_n), StValid, 1'b0);
					res_cnt           = res_cnt + 3'd1;
					total_n           = total_n + 9'(label_n) + 9'd1;
					label_n           = 6'd0;
					label_has_n       = 1'b0;
				end
			end

			// end of name
			if (last_s1 && !done) begin
				clear_n = 1'b1;
				if (failed_n || (!dot && (esc_n != ESC_NONE || label_n == 6'd0))) begin
					res[res_cnt[1:0]] = make_res(8'd0, 8'd0, StInvalid, 1'b1);
					res_cnt           = res_cnt + 3'd1;
				end else if (dot) begin
					res[res_cnt[1:0]] = make_res(total_n[7:0], 8'd0, StValid, 1'b0);
					res_cnt           = res_cnt + 3'd1;
					res[res_cnt[1:0]] = make_res(8'd0, total_n[7:0], StValid, 1'b1);
					res_cnt           = res_cnt + 3'd1;
				end else begin
					res[res_cnt[1:0]] = make_res(total_n[7:0], 8'(label_n), StValid, 1'b0);
					res_cnt           = res_cnt + 3'd1;
					total_n           = total_n + 9'(label_n) + 9'd1;
					res[res_cnt[1:0]] = make_res(total_n[7:0], OpenEndByte, StValid, 1'b0);
					res_cnt           = res_cnt + 3'd1;
					res[res_cnt[1:0]] = make_res(8'd0, total_n[7:0], StPartial, 1'b1);
					res_cnt           = res_cnt + 3'd1;
				end
			end
		end
	end

	assign load_fin = advance && clear_n;

	// input item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1    <= ch;
			last_s1  <= last_char;
			empty_s1 <= empty_name;
		end
	end

	// name state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q       <= ESC_NONE;
			esc_val_q   <= 7'd0;
			label_q     <= 6'd0;
			label_has_q <= 1'b0;
			total_q     <= 9'd1;
			chars_q     <= 11'd0;
			failed_q    <= 1'b0;
		end else if (advance) begin
			if (clear_n) begin
				esc_q       <= ESC_NONE;
				esc_val_q   <= 7'd0;
				label_q     <= 6'd0;
				label_has_q <= 1'b0;
				total_q     <= 9'd1;
				chars_q     <= 11'd0;
				failed_q    <= 1'b0;
			end else begin
				esc_q       <= esc_n;
				esc_val_q   <= esc_val_n;
				label_q     <= label_n;
				label_has_q <= label_has_n;
				total_q     <= total_n;
				chars_q     <= chars_n;
				failed_q    <= failed_n;
			end
		end
	end

	// burst count and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_cnt_q <= 3'd0;
			burst_idx_q <= 2'd0;
		end else if (advance) begin
			burst_cnt_q <= res_cnt;
			burst_idx_q <= 2'd0;
		end else if (last_pop) begin
			burst_cnt_q <= 3'd0;
			burst_idx_q <= 2'd0;
		end else if (pop) begin
			burst_idx_q <= burst_idx_q + 2'd1;
		end
	end

	// burst payload
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < MaxBurst; i++) begin
				burst_q[i] <= res[i];
			end
		end
	end

`ifndef ASSERT_OFF
	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, burst_idx_q} < burst_cnt_q))
		else $error("burst read index beyond burst count");

	a_label_limit: assert property (@(posedge clk) disable iff (!arst_n)
		label_q <= 6'(LabelMax))
		else $error("open label longer than allowed");

	a_total_limit: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= 9'(WireMax))
		else $error("wire length over limit");

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		load_fin |=> (total_q == 9'd1 && chars_q == 11'd0 && !failed_q))
		else $error("name state not cleared after final result");

	a_status_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !final_result) |-> (status == StValid))
		else $error("status set on a non-final result item");
`endif

endmodule

// ===== sim/dns_name_text_to_wire_top_tb.sv =====
`timescale 1ns / 100ps

module dns_name_text_to_wire_top_tb;
	import dntw_pkg::*;

	localparam int ResetCycles = 9;
	localparam int MaxGap      = 14;
	localparam int HoldCycles  = 300;
	localparam int QuietLimit  = 3000;
	localparam int DrainCycles = 40;
	localparam int RandomItems = 80;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] ch;
	logic       last_char;
	logic       empty_name;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] wire_offset;
	logic [7:0] wire_byte;
	logic [1:0] status;
	logic       final_result;

	dns_name_text_to_wire_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.ch           (ch),
		.last_char    (last_char),
		.empty_name   (empty_name),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.wire_offset  (wire_offset),
		.wire_byte    (wire_byte),
		.status       (status),
		.final_result (final_result)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected buffer writes, oldest first
	res_t wire_writes[$];
	logic [7:0] name_chars[$];

	int  mismatches;
	int  items_sent;
	int  hold_cycles;
	int  quiet_cycles;
	logic send_idle;
	logic recv_idle;

	// predicted name state
	esc_t        esc_phase;
	logic [9:0]  esc_val;
	logic [6:0]  lbl_bytes;
	logic        lbl_chars;
	logic [8:0]  wire_len;
	logic [10:0] text_count;
	logic        name_bad;

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic void clear_name();
		esc_phase  = ESC_NONE;
		esc_val    = '0;
		lbl_bytes  = '0;
		lbl_chars  = 1'b0;
		wire_len   = 9'd1;
		text_count = '0;
		name_bad   = 1'b0;
	endfunction

	function automatic void push_write(input logic [7:0] off, input logic [7:0] val,
			input logic [1:0] st, input logic fin);
		res_t w;
		w.wire_offset  = off;
		w.wire_byte    = val;
		w.status       = st;
		w.final_result = fin;
		wire_writes.push_back(w);
	endfunction

	// closing write of the overall length, or of zero for an invalid name, then back to a fresh name
	function automatic void end_name(input logic [1:0] st);
		if (st == StInvalid)
			push_write(8'd0, 8'd0, StInvalid, 1'b1);
		else
			push_write(8'd0, wire_len[7:0], st, 1'b1);
		clear_name();
	endfunction

	function automatic void close_label();
		push_write(wire_len[7:0], {1'b0, lbl_bytes}, StValid, 1'b0);
		wire_len  = wire_len + lbl_bytes + 9'd1;
		lbl_bytes = '0;
		lbl_chars = 1'b0;
	endfunction

	// writes caused by one accepted character item
	function automatic void predict_wire(input logic [7:0] c, input logic lst,
			input logic emp);
		logic       rdy;
		logic       dot;
		logic       dig;
		logic [7:0] b;
		int         v;
		int         nl;
		int         off;
		rdy = 1'b0;
		dot = 1'b0;
		b   = 8'd0;

		// zero-length name item
		if (emp) begin
			if (!name_bad && text_count == 0) begin
				push_write(wire_len[7:0], OpenEndByte, StValid, 1'b0);
				end_name(StPartial);
			end else begin
				end_name(StInvalid);
			end
			return;
		end

		if (text_count < CountSat)
			text_count++;
		if (text_count > MaxTextChars)
			name_bad = 1'b1;

		// escape decoding
		if (!name_bad) begin
			dig = (c >= ChDigit0) && (c <= ChDigit9);
			case (esc_phase)
				ESC_NONE: begin
					if (c == ChBackslash) begin
						esc_phase = ESC_START;
						lbl_chars = 1'b1;
					end else if (c == ChDot) begin
						dot = 1'b1;
					end else begin
						b = c;
						rdy = 1'b1;
						lbl_chars = 1'b1;
					end
				end
				ESC_START: begin
					if (dig) begin
						esc_val = 10'(c - ChDigit0);
						esc_phase = ESC_ONE;
					end else begin
						b = c;
						rdy = 1'b1;
						esc_phase = ESC_NONE;
					end
				end
				ESC_ONE: begin
					if (dig) begin
						esc_val = 10'(esc_val * 10 + (c - ChDigit0));
						esc_phase = ESC_TWO;
					end else begin
						name_bad = 1'b1;
					end
				end
				default: begin
					if (dig) begin
						v = esc_val * 10 + (c - ChDigit0);
						if (v > WireMax) begin
							name_bad = 1'b1;
						end else begin
							b = v[7:0];
							rdy = 1'b1;
							esc_phase = ESC_NONE;
							esc_val = '0;
						end
					end else begin
						name_bad = 1'b1;
					end
				end
			endcase
		end

		// data byte of the open label
		if (!name_bad && rdy) begin
			nl = lbl_bytes + 1;
			if (b >= ChUpperA && b <= ChUpperZ)
				b = b + LowerOffset;
			if (nl > LabelMax || nl + 1 + wire_len > WireMax) begin
				name_bad = 1'b1;
			end else begin
				off = wire_len + nl;
				push_write(off[7:0], b, StValid, 1'b0);
				lbl_bytes = nl[6:0];
			end
		end

		// label end, a lone dot is the root name
		if (!name_bad && dot) begin
			if (!lbl_chars) begin
				if (lst && text_count == 1) begin
					push_write(wire_len[7:0], 8'd0, StValid, 1'b0);
					end_name(StValid);
					return;
				end
				name_bad = 1'b1;
			end else begin
				close_label();
			end
		end

		// end of name
		if (!lst)
			return;
		if (name_bad) begin
			end_name(StInvalid);
			return;
		end
		if (dot) begin
			push_write(wire_len[7:0], 8'd0, StValid, 1'b0);
			end_name(StValid);
			return;
		end
		if (esc_phase != ESC_NONE || lbl_bytes == 0) begin
			end_name(StInvalid);
			return;
		end
		close_label();
		push_write(wire_len[7:0], OpenEndByte, StValid, 1'b0);
		end_name(StPartial);
	endfunction

	// offer one item, hold it until accepted
	task automatic send_item(input logic [7:0] c, input logic lst, input logic emp);
		int   gap;
		logic took;
		gap = send_idle ? $urandom_range(0, MaxGap) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		ch         <= c;
		last_char  <= lst;
		empty_name <= emp;
		do begin
			@(negedge clk);
			took = (in_ready === 1'b1);
			@(posedge clk);
		end while (!took);
		predict_wire(c, lst, emp);
		items_sent++;
	endtask

	task automatic send_name_chars();
		int n;
		n = name_chars.size();
		for (int k = 0; k < n; k++)
			send_item(name_chars[k], k == n - 1, 1'b0);
		name_chars.delete();
	endtask

	task automatic send_str(input string s);
		for (int k = 0; k < s.len(); k++)
			name_chars.push_back(s[k]);
		send_name_chars();
	endtask

	task automatic push_run(input logic [7:0] c, input int n);
		for (int k = 0; k < n; k++)
			name_chars.push_back(c);
	endtask

	task automatic push_dec_escape(input int v);
		name_chars.push_back(ChBackslash);
		name_chars.push_back(8'(ChDigit0 + v / 100));
		name_chars.push_back(8'(ChDigit0 + (v / 10) % 10));
		name_chars.push_back(8'(ChDigit0 + v % 10));
	endtask

	// plain names, root, empty name, raw byte extremes
	task automatic test_plain_names();
		send_str("a.");
		send_str("Ab");
		send_str(".");
		send_item(8'h00, 1'b0, 1'b1);
		name_chars.push_back(8'h00);
		name_chars.push_back(8'hFF);
		name_chars.push_back(ChDot);
		send_name_chars();
		send_str("xZ.q");
	endtask

	// literal and decimal escapes, good and broken
	task automatic test_escapes();
		send_str("\\065.");
		send_str("\\255\\000.");
		send_str("\\..");
		send_str("\\Z.");
		send_str("\\256.");
		send_str("\\1x.");
		send_str("\\12");
		send_str("a\\");
	endtask

	// empty labels, long label, wire length, unfinished name
	task automatic test_malformed();
		send_str("a..b.");
		send_str(".a.");
		push_run(8'h61, LabelMax + 1);
		name_chars.push_back(ChDot);
		send_name_chars();
		for (int k = 0; k < 3; k++) begin
			push_run(8'h62, LabelMax);
			name_chars.push_back(ChDot);
		end
		push_run(8'h62, 62);
		name_chars.push_back(ChDot);
		send_name_chars();
		send_item(8'h61, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_stall();
		send_idle   = 1'b0;
		hold_cycles = HoldCycles;
		repeat (6) send_str("abc.de.");
		send_idle = 1'b1;
	endtask

	task automatic send_random_name();
		int nlab;
		int len;
		int v;
		nlab = $urandom_range(1, 4);
		if ($urandom_range(0, 29) == 0) begin
			name_chars.push_back(ChDot);
		end else begin
			for (int l = 0; l < nlab; l++) begin
				if ($urandom_range(0, 24) == 0)
					name_chars.push_back(ChDot);
				len = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 66) :
					$urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					case ($urandom_range(0, 19))
						0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
							name_chars.push_back(8'(8'h61 + $urandom_range(0, 25)));
						10, 11:
							name_chars.push_back(8'(ChUpperA + $urandom_range(0, 25)));
						12, 13:
							name_chars.push_back(8'(ChDigit0 + $urandom_range(0, 9)));
						14:
							name_chars.push_back(8'h2D);
						15, 16: begin
							name_chars.push_back(ChBackslash);
							name_chars.push_back(8'($urandom_range(0, 255)));
						end
						17, 18: begin
							v = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 299) :
								$urandom_range(0, 255);
							push_dec_escape(v);
						end
						default:
							name_chars.push_back(8'($urandom_range(0, 255)));
					endcase
				end
				if (l != nlab - 1 || $urandom_range(0, 1) == 1)
					name_chars.push_back(ChDot);
			end
		end
		send_name_chars();
	endtask

	// random items, always closed by a last item
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int k = 0; k < n; k++)
			send_item(8'($urandom_range(0, 255)), k == n - 1 || $urandom_range(0, 3) == 0,
				$urandom_range(0, 7) == 0);
	endtask

	task automatic test_random_names();
		int stop;
		int mode;
		stop = items_sent + RandomItems;
		while (items_sent < stop) begin
			mode = $urandom_range(0, 3);
			send_idle = mode[0];
			recv_idle = mode[1];
			if ($urandom_range(0, 5) == 0)
				send_noise();
			else
				send_random_name();
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// result receiver with random stalls and the long hold-off
	initial begin : result_sink
		int   gap;
		logic took;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			gap = recv_idle ? $urandom_range(0, MaxGap) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				took = (out_valid === 1'b1);
				@(posedge clk);
			end while (!took);
		end
	end

	// compare each accepted result with the oldest expectation
	always @(negedge clk) begin : result_check
		res_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (wire_writes.size() == 0) begin
				flag_mismatch($sformatf("unexpected item offset %0d byte %0d",
					wire_offset, wire_byte));
			end else begin
				want = wire_writes.pop_front();
				if (wire_offset !== want.wire_offset)
					flag_mismatch($sformatf("wire_offset %0d, want %0d",
						wire_offset, want.wire_offset));
				if (wire_byte !== want.wire_byte)
					flag_mismatch($sformatf("wire_byte %0d, want %0d at offset %0d",
						wire_byte, want.wire_byte, want.wire_offset));
				if (status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (final_result !== want.final_result)
					flag_mismatch($sformatf("final_result %0b, want %0b",
						final_result, want.final_result));
			end
		end
	end

	// watchdog on cycles with no accepted item on either side
	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid === 1'b1 && in_ready === 1'b1) ||
					(out_valid === 1'b1 && out_ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		ch           = 8'd0;
		last_char    = 1'b0;
		empty_name   = 1'b0;
		out_ready    = 1'b0;
		send_idle    = 1'b1;
		recv_idle    = 1'b1;
		hold_cycles  = 0;
		quiet_cycles = 0;
		mismatches   = 0;
		items_sent   = 0;
		clear_name();
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_names();
		test_escapes();
		test_malformed();
		test_output_stall();
		test_random_names();
		in_valid <= 1'b0;

		// drain outstanding results
		while (wire_writes.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
